[rtl/ogrm_pkg.sv]
// Shared types and constants for the occupancy grid ray marker.
package ogrm_pkg;

   localparam int COORD_W = 11;
   localparam int DELTA_W = 12;

   localparam logic [7:0] CELL_FREE     = 8'd0;
   localparam logic [7:0] CELL_OCCUPIED = 8'd100;
   localparam logic [7:0] CELL_UNKNOWN  = 8'd255;

   localparam logic CMD_PLOT = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic CSR_ORIGIN_X = 1'b0;
   localparam logic CSR_ORIGIN_Y = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DELTA_W-1:0] delta_type;

   // Bresenham walker state for one ray
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type xe;
      coord_type ye;
      delta_type dx;
      delta_type dy;
      logic      sx_neg;
      logic      sy_neg;
      delta_type err;
   } ray_state_type;

   // Result of one walker step
   typedef struct packed {
      logic      active;
      coord_type x;
      coord_type y;
      delta_type err;
   } ray_step_type;

endpackage

[rtl/occupancy_grid_ray_marker_top.sv]
// Top level of the occupancy grid ray marker: grid memory, sequencer, output register.
//
//   channel | direction | transfer when         | payload
//   req     | in        | req_valid & req_ready | req_cmd, req_cell_x, req_cell_y, req_mark_value
//   rsp     | out       | rsp_valid & rsp_ready | rsp_cell_value, rsp_inside_grid
//   csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// A read looks up its cell at the transfer, then passes ST_READ and ST_RESP. A plot walks
// the cells on the ray in ST_TRACE (at most one grid span), one read-modify-write per cell
// pipelined through the single grid memory, then passes ST_MARK and ST_RESP.
// After reset a clearing pass writes unknown to all GRID_WIDTH * GRID_HEIGHT cells, one
// per cycle, with req_ready low. A result waiting in the output register stalls only
// the end of the next item, not its transfer.
module occupancy_grid_ray_marker_top #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic signed [9:0] req_cell_x,
   input  logic signed [9:0] req_cell_y,
   input  logic [7:0]        req_mark_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_cell_value,
   output logic              rsp_inside_grid,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [7:0]        csr_wdata
);

   localparam int GridDepth = GRID_WIDTH * GRID_HEIGHT;
   localparam int AddrW     = $clog2(GridDepth);
   localparam int CW        = ogrm_pkg::COORD_W;
   localparam int DW        = ogrm_pkg::DELTA_W;
   localparam ogrm_pkg::coord_type WidthS  = $signed(CW'(GRID_WIDTH));
   localparam ogrm_pkg::coord_type HeightS = $signed(CW'(GRID_HEIGHT));

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TRACE,
      ST_MARK,
      ST_READ,
      ST_RESP
   } state_type;

   function automatic logic [AddrW-1:0] cell_addr(input ogrm_pkg::coord_type x,
                                                  input ogrm_pkg::coord_type y);
      return AddrW'($unsigned(x)) * AddrW'(GRID_HEIGHT) + AddrW'($unsigned(y));
   endfunction

   state_type                state_ff;
   logic [AddrW-1:0]         clr_ff;
   logic [7:0]               origin_x_ff;
   logic [7:0]               origin_y_ff;
   ogrm_pkg::ray_state_type  ray_ff;
   ogrm_pkg::ray_step_type   step;
   logic                     inside_ff;
   logic [7:0]               mark_ff;
   logic [7:0]               value_ff;
   logic                     pend_ff;
   logic [AddrW-1:0]         pend_addr_ff;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_value_ff;
   logic                     rsp_inside_ff;

   logic [7:0]               grid_mem [GridDepth];
   logic [7:0]               mem_rdata_ff;
   logic                     mem_re;
   logic [AddrW-1:0]         mem_raddr;
   logic                     mem_we;
   logic [AddrW-1:0]         mem_waddr;
   logic [7:0]               mem_wdata;

   ogrm_pkg::coord_type      req_x;
   ogrm_pkg::coord_type      req_y;
   ogrm_pkg::coord_type      org_x;
   ogrm_pkg::coord_type      org_y;
   ogrm_pkg::delta_type      diff_x;
   ogrm_pkg::delta_type      diff_y;
   ogrm_pkg::delta_type      abs_x;
   ogrm_pkg::delta_type      abs_y;
   logic                     req_inside;
   logic                     req_fire;
   logic                     rsp_free;

   ogrm_ray_step #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_step (
      .ray  (ray_ff),
      .step (step)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_value_ff;
   assign rsp_inside_grid = rsp_inside_ff;

   always_comb begin
      req_x  = CW'(req_cell_x);
      req_y  = CW'(req_cell_y);
      org_x  = $signed(CW'(origin_x_ff));
      org_y  = $signed(CW'(origin_y_ff));
      diff_x = DW'(req_x) - DW'(org_x);
      diff_y = DW'(req_y) - DW'(org_y);
      abs_x  = diff_x[DW-1] ? -diff_x : diff_x;
      abs_y  = diff_y[DW-1] ? -diff_y : diff_y;
      req_inside = !req_x[CW-1] && (req_x < WidthS) && !req_y[CW-1] && (req_y < HeightS);
   end

   // Read port: cell reads and ray reads; write port: clear, free, mark
   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = cell_addr(ray_ff.x, ray_ff.y);
      if (state_ff == ST_IDLE) begin
         mem_re    = req_fire && (req_cmd == ogrm_pkg::CMD_READ);
         mem_raddr = cell_addr(req_x, req_y);
      end else if (state_ff == ST_TRACE) begin
         mem_re = step.active;
      end

      mem_we    = 1'b0;
      mem_waddr = pend_addr_ff;
      mem_wdata = ogrm_pkg::CELL_FREE;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = ogrm_pkg::CELL_UNKNOWN;
         end
         ST_MARK: begin
            mem_we    = inside_ff;
            mem_waddr = cell_addr(ray_ff.xe, ray_ff.ye);
            mem_wdata = mark_ff;
         end
         default: begin
            // leave occupied cells alone
            mem_we = pend_ff && (mem_rdata_ff != ogrm_pkg::CELL_OCCUPIED);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= grid_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ogrm_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            ogrm_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once taken, unless a new one loads this cycle
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AddrW'(GridDepth - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_fire) begin
                  inside_ff     <= req_inside;
                  mark_ff       <= req_mark_value;
                  value_ff      <= '0;
                  ray_ff.x      <= org_x;
                  ray_ff.y      <= org_y;
                  ray_ff.xe     <= req_x;
                  ray_ff.ye     <= req_y;
                  ray_ff.dx     <= abs_x;
                  ray_ff.dy     <= abs_y;
                  ray_ff.sx_neg <= !(org_x < req_x);
                  ray_ff.sy_neg <= !(org_y < req_y);
                  ray_ff.err    <= abs_x - abs_y;
                  state_ff      <= (req_cmd == ogrm_pkg::CMD_READ) ? ST_READ : ST_TRACE;
               end
            end
            ST_TRACE: begin
               // issue the read for this cell, write it back next cycle
               pend_ff      <= step.active;
               pend_addr_ff <= cell_addr(ray_ff.x, ray_ff.y);
               if (step.active) begin
                  ray_ff.x   <= step.x;
                  ray_ff.y   <= step.y;
                  ray_ff.err <= step.err;
               end else begin
                  state_ff <= ST_MARK;
               end
            end
            ST_MARK: begin
               state_ff <= ST_RESP;
            end
            ST_READ: begin
               value_ff <= inside_ff ? mem_rdata_ff : '0;
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= value_ff;
                  rsp_inside_ff <= inside_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/ogrm_ray_step.sv]
// One Bresenham step: grid bounds check, end test and next position.
module ogrm_ray_step #(
   parameter int GRID_WIDTH  = 256,
   parameter int GRID_HEIGHT = 256
) (
   input  ogrm_pkg::ray_state_type ray,
   output ogrm_pkg::ray_step_type  step
);

   localparam int E2W = ogrm_pkg::DELTA_W + 1;
   localparam ogrm_pkg::coord_type WidthS  = $signed(ogrm_pkg::COORD_W'(GRID_WIDTH));
   localparam ogrm_pkg::coord_type HeightS = $signed(ogrm_pkg::COORD_W'(GRID_HEIGHT));

   logic signed [E2W-1:0] e2;
   logic signed [E2W-1:0] neg_dy;
   logic signed [E2W-1:0] dx_ext;
   logic                  step_x;
   logic                  step_y;
   logic                  in_grid;
   logic                  at_end;

   always_comb begin
      e2     = $signed({ray.err, 1'b0});
      neg_dy = -$signed(E2W'(ray.dy));
      dx_ext = $signed(E2W'(ray.dx));
      step_x = e2 > neg_dy;
      step_y = e2 < dx_ext;

      in_grid = !ray.x[ogrm_pkg::COORD_W-1] && (ray.x < WidthS) &&
                !ray.y[ogrm_pkg::COORD_W-1] && (ray.y < HeightS);
      at_end  = (ray.x == ray.xe) && (ray.y == ray.ye);

      step.active = in_grid && !at_end;
      step.err    = ray.err - (step_x ? ray.dy : '0) + (step_y ? ray.dx : '0);
      step.x      = !step_x ? ray.x : (ray.sx_neg ? ray.x - 11'sd1 : ray.x + 11'sd1);
      step.y      = !step_y ? ray.y : (ray.sy_neg ? ray.y - 11'sd1 : ray.y + 11'sd1);
   end

endmodule
